// File: hdl/ccfsa_pkg.sv
// ----------------------------------------------------------------------------
// ccfsa_pkg
// Shared constants, types and face-to-cell tables for the cube face sample
// address generator.
// ----------------------------------------------------------------------------
package ccfsa_pkg;

  localparam int unsigned MAX_IMAGE_DIM = 8192;
  localparam int unsigned MAX_FACE_SIZE = 4096;
  localparam int unsigned MAX_BPP       = 16;
  localparam int unsigned FACE_COUNT    = 6;

  localparam int unsigned FACE_W     = 3;
  localparam int unsigned DEST_W     = 12;
  localparam int unsigned SRC_W      = 13;
  localparam int unsigned OFF_W      = 30;
  localparam int unsigned CFG_DIM_W  = 14;
  localparam int unsigned CFG_FS_W   = 13;
  localparam int unsigned CFG_BPP_W  = 5;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned DIM_W    = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned CELL_W   = $clog2(MAX_IMAGE_DIM / 4 + 1);
  localparam int unsigned FS_W     = $clog2(MAX_FACE_SIZE + 1);
  localparam int unsigned DEN_W    = FS_W + 1;
  localparam int unsigned BPP_W    = $clog2(MAX_BPP + 1);
  localparam int unsigned STRIDE_W = DIM_W + BPP_W;
  localparam int unsigned NUM_W    = DEST_W + 1 + CELL_W;
  localparam int unsigned QUO_W    = SRC_W;
  localparam int unsigned ORG_W    = CELL_W + 2;
  localparam int unsigned CMP_W    = DEN_W + QUO_W;
  localparam int unsigned PY_W     = SRC_W + STRIDE_W;
  localparam int unsigned PX_W     = SRC_W + BPP_W;

  localparam int unsigned DIV3_SHIFT = 17;
  localparam int unsigned DIV3_MUL   = (1 << DIV3_SHIFT) / 3 + 1;

  localparam int unsigned BACK_STAGES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_FACE_SIZE       = 2'd2,
    REG_BYTES_PER_PIXEL = 2'd3
  } cfg_reg_e;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [CELL_W-1:0]   cell_w;
    logic [CELL_W-1:0]   cell_h;
    logic [DEN_W-1:0]    den;
    logic [BPP_W-1:0]    bpp;
    logic [STRIDE_W-1:0] stride;
    logic                bad;
  } geom_t;

  typedef struct packed {
    logic             invalid;
    logic [ORG_W-1:0] org;
  } lane_tag_t;

  typedef struct packed {
    logic             ovf;
    logic [QUO_W-1:0] quo;
    lane_tag_t        tag;
  } div_res_t;

  function automatic logic [1:0] cell_col(input logic [FACE_W-1:0] face);
    logic [1:0] c;
    unique case (face) inside
      FACE_POS_X:                         c = 2'd2;
      FACE_NEG_X:                         c = 2'd0;
      FACE_POS_Y, FACE_NEG_Y, FACE_POS_Z: c = 2'd1;
      FACE_NEG_Z:                         c = 2'd3;
      default:                            c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] cell_row(input logic [FACE_W-1:0] face);
    logic [1:0] r;
    unique case (face) inside
      FACE_POS_Y:                                     r = 2'd0;
      FACE_NEG_Y:                                     r = 2'd2;
      FACE_POS_X, FACE_NEG_X, FACE_POS_Z, FACE_NEG_Z: r = 2'd1;
      default:                                        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/cube_cross_face_sample_address.sv
// ----------------------------------------------------------------------------
// cube_cross_face_sample_address
// Nearest-neighbour source address for one cube face pixel of a 4x3 cross.
// ----------------------------------------------------------------------------
// One destination pixel enters per cycle unless the pipeline is stalled or the
// input is held after a configuration transfer. Its source column, row and byte
// offset pass one decode stage (cell origin and the two (2d+1)*cell products),
// 13 divider stages that each settle one quotient bit of the division by twice
// the face size, then clamp, offset multiply and offset add with the output
// register. Stages advance independently, so bubbles close up while the output
// is stalled. After a configuration transfer the input side is held while the
// derived geometry registers settle.
module cube_cross_face_sample_address import ccfsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // dest_x[11:0], dest_y[23:12]
  input  logic [FACE_W-1:0]     s_axis_tuser,  // face_number[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // source_x[12:0], source_y[25:13],
                                               // source_offset[55:26]
  output logic                  m_axis_tuser   // invalid[0]
);

  localparam int unsigned NS = 1 + QUO_W + BACK_STAGES;

  geom_t            geom;
  logic [NS-1:0]    valid_q, valid_d, en;
  logic             cfg_wr_q;
  logic             cfg_ready;
  logic [NUM_W-1:0] num_x, num_y;
  lane_tag_t        tag_x, tag_y;
  div_res_t         res_x, res_y;
  logic [SRC_W-1:0] source_x, source_y;
  logic [OFF_W-1:0] source_offset;
  logic             invalid;

  assign en[NS-1] = ~valid_q[NS-1] | m_axis_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = ~valid_q[k] | en[k+1];
  end

  assign s_axis_tready = en[0] & ~cfg_wr_q;
  assign valid_d       = {valid_q[NS-2:0], s_axis_tvalid & ~cfg_wr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cfg_wr_q <= 1'b0;
    end else begin
      valid_q  <= (valid_q & ~en) | (valid_d & en);
      cfg_wr_q <= cfg_valid_i & cfg_ready;
    end
  end

  ccfsa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  assign cfg_ready_o = cfg_ready;

  ccfsa_front u_front (
    .clk_i         (clk_i),
    .en_i          (en[0]),
    .face_number_i (s_axis_tuser),
    .dest_x_i      (s_axis_tdata[DEST_W-1:0]),
    .dest_y_i      (s_axis_tdata[2*DEST_W-1:DEST_W]),
    .geom_i        (geom),
    .num_x_o       (num_x),
    .num_y_o       (num_y),
    .tag_x_o       (tag_x),
    .tag_y_o       (tag_y)
  );

  ccfsa_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en[QUO_W:1]),
    .den_i (geom.den),
    .num_i (num_x),
    .tag_i (tag_x),
    .res_o (res_x)
  );

  ccfsa_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en[QUO_W:1]),
    .den_i (geom.den),
    .num_i (num_y),
    .tag_i (tag_y),
    .res_o (res_y)
  );

  ccfsa_back u_back (
    .clk_i           (clk_i),
    .en_i            (en[NS-1 -: BACK_STAGES]),
    .res_x_i         (res_x),
    .res_y_i         (res_y),
    .geom_i          (geom),
    .source_x_o      (source_x),
    .source_y_o      (source_y),
    .source_offset_o (source_offset),
    .invalid_o       (invalid)
  );

  assign m_axis_tvalid = valid_q[NS-1];
  assign m_axis_tdata  = {source_offset, source_y, source_x};
  assign m_axis_tuser  = invalid;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && invalid |-> source_x == '0 && source_y == '0 && source_offset == '0)
    else $error("invalid result carries a non-zero address");

  a_inside_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !invalid |->
      DIM_W'(source_x) < geom.width && DIM_W'(source_y) < geom.height)
    else $error("source coordinate outside the image");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !cfg_wr_q |-> s_axis_tready)
    else $error("input held although the output register is empty");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && en[1] |=> valid_q[1])
    else $error("decoded item lost on its way into the divider");

endmodule

// File: hdl/ccfsa_cfg.sv
// ----------------------------------------------------------------------------
// ccfsa_cfg
// Configuration registers and the registered cross geometry derived from them.
// ----------------------------------------------------------------------------
module ccfsa_cfg import ccfsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output geom_t                 geom_o
);

  logic [CFG_DIM_W-1:0] img_w_q, img_w_d;
  logic [CFG_DIM_W-1:0] img_h_q, img_h_d;
  logic [CFG_FS_W-1:0]  face_size_q, face_size_d;
  logic [CFG_BPP_W-1:0] bpp_q, bpp_d;
  geom_t                geom_q, geom_d;

  logic [DIM_W-1:0]            w_sat;
  logic [DIM_W-1:0]            h_sat;
  logic [FS_W-1:0]             fs_sat;
  logic [BPP_W-1:0]            bpp_sat;
  logic [DIM_W+DIV3_SHIFT-1:0] h_prod;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    img_w_d     = img_w_q;
    img_h_d     = img_h_q;
    face_size_d = face_size_q;
    bpp_d       = bpp_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:     img_w_d     = cfg_data_i[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:    img_h_d     = cfg_data_i[CFG_DIM_W-1:0];
        REG_FACE_SIZE:       face_size_d = cfg_data_i[CFG_FS_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_d       = cfg_data_i[CFG_BPP_W-1:0];
      endcase
    end
  end

  always_comb begin
    w_sat   = (img_w_q > CFG_DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : DIM_W'(img_w_q);
    h_sat   = (img_h_q > CFG_DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : DIM_W'(img_h_q);
    fs_sat  = (face_size_q > CFG_FS_W'(MAX_FACE_SIZE)) ? FS_W'(MAX_FACE_SIZE)
                                                       : FS_W'(face_size_q);
    if (bpp_q > CFG_BPP_W'(MAX_BPP)) begin
      bpp_sat = BPP_W'(MAX_BPP);
    end else if (bpp_q == '0) begin
      bpp_sat = BPP_W'(1);
    end else begin
      bpp_sat = BPP_W'(bpp_q);
    end
    h_prod = (DIM_W+DIV3_SHIFT)'(h_sat) * (DIM_W+DIV3_SHIFT)'(DIV3_MUL);

    geom_d.width  = w_sat;
    geom_d.height = h_sat;
    geom_d.cell_w = w_sat[2 +: CELL_W];
    geom_d.cell_h = h_prod[DIV3_SHIFT +: CELL_W];
    geom_d.den    = {fs_sat, 1'b0};
    geom_d.bpp    = bpp_sat;
    geom_d.stride = STRIDE_W'(w_sat) * STRIDE_W'(bpp_sat);
    geom_d.bad    = (fs_sat == '0) || (w_sat < DIM_W'(4)) || (h_sat < DIM_W'(3));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q     <= '0;
      img_h_q     <= '0;
      face_size_q <= '0;
      bpp_q       <= CFG_BPP_W'(4);
      geom_q      <= '{width: '0, height: '0, cell_w: '0, cell_h: '0, den: '0,
                       bpp: BPP_W'(4), stride: '0, bad: 1'b1};
    end else begin
      img_w_q     <= img_w_d;
      img_h_q     <= img_h_d;
      face_size_q <= face_size_d;
      bpp_q       <= bpp_d;
      geom_q      <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

// File: hdl/ccfsa_front.sv
// ----------------------------------------------------------------------------
// ccfsa_front
// Decode stage: face to cell origin, dividend (2d+1)*cell and invalid flag.
// ----------------------------------------------------------------------------
module ccfsa_front import ccfsa_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [FACE_W-1:0] face_number_i,
  input  logic [DEST_W-1:0] dest_x_i,
  input  logic [DEST_W-1:0] dest_y_i,
  input  geom_t             geom_i,
  output logic [NUM_W-1:0]  num_x_o,
  output logic [NUM_W-1:0]  num_y_o,
  output lane_tag_t         tag_x_o,
  output lane_tag_t         tag_y_o
);

  logic [NUM_W-1:0] num_x_q, num_x_d;
  logic [NUM_W-1:0] num_y_q, num_y_d;
  lane_tag_t        tag_x_q, tag_x_d;
  lane_tag_t        tag_y_q, tag_y_d;
  logic             invalid;

  always_comb begin
    invalid = geom_i.bad || (face_number_i >= FACE_W'(FACE_COUNT));
    num_x_d = NUM_W'({dest_x_i, 1'b1}) * NUM_W'(geom_i.cell_w);
    num_y_d = NUM_W'({dest_y_i, 1'b1}) * NUM_W'(geom_i.cell_h);
    tag_x_d.invalid = invalid;
    tag_x_d.org     = ORG_W'(cell_col(face_number_i)) * ORG_W'(geom_i.cell_w);
    tag_y_d.invalid = invalid;
    tag_y_d.org     = ORG_W'(cell_row(face_number_i)) * ORG_W'(geom_i.cell_h);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_x_q <= num_x_d;
      num_y_q <= num_y_d;
      tag_x_q <= tag_x_d;
      tag_y_q <= tag_y_d;
    end
  end

  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign tag_x_o = tag_x_q;
  assign tag_y_o = tag_y_q;

endmodule

// File: hdl/ccfsa_div.sv
// ----------------------------------------------------------------------------
// ccfsa_div
// Pipelined restoring divider lane, one quotient bit per stage, with an
// overflow flag for quotients beyond the coordinate range.
// ----------------------------------------------------------------------------
module ccfsa_div import ccfsa_pkg::*; (
  input  logic             clk_i,
  input  logic [QUO_W-1:0] en_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [NUM_W-1:0] num_i,
  input  lane_tag_t        tag_i,
  output div_res_t         res_o
);

  logic [NUM_W-1:0] rem_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             ovf_q [QUO_W];
  lane_tag_t        tag_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic             ovf_in;
    lane_tag_t        tag_in;
    logic [CMP_W-1:0] dsh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign ovf_in = (CMP_W'(num_i) >= (CMP_W'(den_i) << QUO_W));
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign ovf_in = ovf_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign dsh = CMP_W'(den_i) << (QUO_W - 1 - i);
    assign ge  = (CMP_W'(rem_in) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        quo_q[i] <= {quo_in[QUO_W-2:0], ge};
        ovf_q[i] <= ovf_in;
        tag_q[i] <= tag_in;
      end
    end

    if (i < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          rem_q[i] <= ge ? NUM_W'(CMP_W'(rem_in) - dsh) : rem_in;
        end
      end
    end
  end

  assign res_o.ovf = ovf_q[QUO_W-1];
  assign res_o.quo = quo_q[QUO_W-1];
  assign res_o.tag = tag_q[QUO_W-1];

endmodule

// File: hdl/ccfsa_back.sv
// ----------------------------------------------------------------------------
// ccfsa_back
// Clamp to the image edge, form the byte offset and hold the result.
// ----------------------------------------------------------------------------
module ccfsa_back import ccfsa_pkg::*; (
  input  logic                   clk_i,
  input  logic [BACK_STAGES-1:0] en_i,
  input  div_res_t               res_x_i,
  input  div_res_t               res_y_i,
  input  geom_t                  geom_i,
  output logic [SRC_W-1:0]       source_x_o,
  output logic [SRC_W-1:0]       source_y_o,
  output logic [OFF_W-1:0]       source_offset_o,
  output logic                   invalid_o
);

  logic [ORG_W:0]     sum_x, sum_y;
  logic               clamp_x, clamp_y, inv;
  logic [SRC_W-1:0]   edge_x, edge_y;

  logic [SRC_W-1:0]   sx_a_q, sx_a_d, sy_a_q, sy_a_d;
  logic               inv_a_q;
  logic [PY_W-1:0]    py_b_q;
  logic [PX_W-1:0]    px_b_q;
  logic [SRC_W-1:0]   sx_b_q, sy_b_q;
  logic               inv_b_q;
  logic [SRC_W-1:0]   sx_c_q, sy_c_q;
  logic [OFF_W-1:0]   off_c_q;
  logic               inv_c_q;

  always_comb begin
    inv     = res_x_i.tag.invalid || res_y_i.tag.invalid;
    sum_x   = (ORG_W+1)'(res_x_i.tag.org) + (ORG_W+1)'(res_x_i.quo);
    sum_y   = (ORG_W+1)'(res_y_i.tag.org) + (ORG_W+1)'(res_y_i.quo);
    clamp_x = res_x_i.ovf || (sum_x >= (ORG_W+1)'(geom_i.width));
    clamp_y = res_y_i.ovf || (sum_y >= (ORG_W+1)'(geom_i.height));
    edge_x  = SRC_W'(geom_i.width - DIM_W'(1));
    edge_y  = SRC_W'(geom_i.height - DIM_W'(1));
    if (inv) begin
      sx_a_d = '0;
      sy_a_d = '0;
    end else begin
      sx_a_d = clamp_x ? edge_x : SRC_W'(sum_x);
      sy_a_d = clamp_y ? edge_y : SRC_W'(sum_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sx_a_q  <= sx_a_d;
      sy_a_q  <= sy_a_d;
      inv_a_q <= inv;
    end
    if (en_i[1]) begin
      py_b_q  <= PY_W'(sy_a_q) * PY_W'(geom_i.stride);
      px_b_q  <= PX_W'(sx_a_q) * PX_W'(geom_i.bpp);
      sx_b_q  <= sx_a_q;
      sy_b_q  <= sy_a_q;
      inv_b_q <= inv_a_q;
    end
    if (en_i[2]) begin
      off_c_q <= OFF_W'(py_b_q + PY_W'(px_b_q));
      sx_c_q  <= sx_b_q;
      sy_c_q  <= sy_b_q;
      inv_c_q <= inv_b_q;
    end
  end

  assign source_x_o      = sx_c_q;
  assign source_y_o      = sy_c_q;
  assign source_offset_o = off_c_q;
  assign invalid_o       = inv_c_q;

endmodule

// File: dv/cube_cross_face_sample_address_tb.sv
// ----------------------------------------------------------------------------
// cube_cross_face_sample_address_tb
// Self-checking bench for the cube face sample address generator.
// ----------------------------------------------------------------------------
// Streams destination pixels through the block under a series of cross image
// geometries, including oversized, degenerate and minimal ones. Each accepted
// pixel is mapped to its expected source column, row, byte offset and invalid
// flag. The mapping is done in exact integer arithmetic. Results are checked
// in order as they leave. Sender gaps and receiver stalls vary from phase to
// phase, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module cube_cross_face_sample_address_tb import ccfsa_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned NUM_PHASES  = 16;
  localparam int unsigned PHASE_ITEMS = 110;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
  } pixel_req_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_x;
    logic [SRC_W-1:0] source_y;
    logic [OFF_W-1:0] source_offset;
    logic             invalid;
  } sample_addr_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;  // dest_x[11:0], dest_y[23:12]
  logic [FACE_W-1:0]     s_axis_tuser  = '0;  // face_number[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [55:0]           m_axis_tdata;        // source_x[12:0], source_y[25:13],
                                              // source_offset[55:26]
  logic                  m_axis_tuser;        // invalid[0]

  logic [CFG_DIM_W-1:0] img_w     = '0;
  logic [CFG_DIM_W-1:0] img_h     = '0;
  logic [CFG_FS_W-1:0]  face_sz   = '0;
  logic [CFG_BPP_W-1:0] pix_bytes = 5'd4;

  pixel_req_t   pixel_q[$];
  sample_addr_t addr_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_req    = 0;
  int unsigned rx_hold_seen   = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;

  cube_cross_face_sample_address uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic sample_addr_t predict_address(pixel_req_t req);
    longint unsigned w, h, fs, bpp, cw, ch, col, row, sx, sy, off;
    sample_addr_t    r;
    w   = (img_w > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : img_w;
    h   = (img_h > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : img_h;
    fs  = (face_sz > MAX_FACE_SIZE) ? MAX_FACE_SIZE : face_sz;
    bpp = (pix_bytes > MAX_BPP) ? MAX_BPP : pix_bytes;
    if (bpp == 0) begin
      bpp = 1;
    end
    cw = w / 4;
    ch = h / 3;
    r  = '0;
    if (fs == 0 || cw == 0 || ch == 0 || req.face > FACE_NEG_Z) begin
      r.invalid = 1'b1;
      return r;
    end
    case (req.face)
      FACE_POS_X: begin col = 2; row = 1; end
      FACE_NEG_X: begin col = 0; row = 1; end
      FACE_POS_Y: begin col = 1; row = 0; end
      FACE_NEG_Y: begin col = 1; row = 2; end
      FACE_POS_Z: begin col = 1; row = 1; end
      default:    begin col = 3; row = 1; end
    endcase
    sx = col * cw + ((2 * longint'(req.dest_x) + 1) * cw) / (2 * fs);
    sy = row * ch + ((2 * longint'(req.dest_y) + 1) * ch) / (2 * fs);
    if (sx >= w) begin
      sx = w - 1;
    end
    if (sy >= h) begin
      sy = h - 1;
    end
    off = sy * w * bpp + sx * bpp;
    r.source_x      = sx[SRC_W-1:0];
    r.source_y      = sy[SRC_W-1:0];
    r.source_offset = off[OFF_W-1:0];
    return r;
  endfunction

  // Sender: predict on each transfer, then offer the next pending pixel.
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.face   = s_axis_tuser;
        req.dest_x = s_axis_tdata[11:0];
        req.dest_y = s_axis_tdata[23:12];
        addr_q.push_back(predict_address(req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req.dest_y, req.dest_x};
          s_axis_tuser  <= req.face;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : hold_counter
    if (!rst_ni) begin
      rx_hold_left <= 0;
      rx_hold_seen <= 0;
    end else if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Receiver: compare each transfer with the oldest expected address.
  always @(posedge clk_i or negedge rst_ni) begin : addr_monitor
    sample_addr_t got, exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.source_x      = m_axis_tdata[12:0];
        got.source_y      = m_axis_tdata[25:13];
        got.source_offset = m_axis_tdata[55:26];
        got.invalid       = m_axis_tuser;
        if (addr_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: x=%0d y=%0d off=%0d inv=%0b", got.source_x,
                     got.source_y, got.source_offset, got.invalid);
          end
        end else begin
          exp = addr_q.pop_front();
          if (got !== exp) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: exp x=%0d y=%0d off=%0d inv=%0b,",
                       exp.source_x, exp.source_y, exp.source_offset, exp.invalid,
                       " got x=%0d y=%0d off=%0d inv=%0b",
                       got.source_x, got.source_y, got.source_offset, got.invalid);
            end
          end
        end
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  img_w     = val;
      REG_IMAGE_HEIGHT: img_h     = val;
      REG_FACE_SIZE:    face_sz   = val[CFG_FS_W-1:0];
      default:          pix_bytes = val[CFG_BPP_W-1:0];
    endcase
  endtask

  task automatic set_geometry(logic [13:0] w, logic [13:0] h, logic [13:0] fs,
                              logic [13:0] bpp);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_FACE_SIZE, fs);
    write_reg(REG_BYTES_PER_PIXEL, bpp);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pixel_q.size() != 0 || s_axis_tvalid || addr_q.size() != 0);
  endtask

  function automatic void queue_pixel(logic [2:0] f, logic [11:0] dx, logic [11:0] dy);
    pixel_req_t req;
    req.face   = f;
    req.dest_x = dx;
    req.dest_y = dy;
    pixel_q.push_back(req);
  endfunction

  // Mostly pixels inside the face, some anywhere in the 12-bit range.
  function automatic void queue_random(int unsigned n);
    int unsigned span;
    logic [2:0]  f;
    logic [11:0] dx, dy;
    span = (face_sz == 0 || face_sz > 4096) ? 4095 : face_sz - 1;
    repeat (n) begin
      f = ($urandom_range(99) < 90) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
      if ($urandom_range(99) < 15) begin
        dx = 12'($urandom);
        dy = 12'($urandom);
      end else begin
        dx = 12'($urandom_range(0, span));
        dy = 12'($urandom_range(0, span));
      end
      queue_pixel(f, dx, dy);
    end
  endfunction

  initial begin : stimulus
    logic [13:0] special_w[7]   = '{14'd8192, 14'h3FFF, 14'd4, 14'd8192, 14'd3, 14'd400, 14'd1024};
    logic [13:0] special_h[7]   = '{14'd8192, 14'h3FFF, 14'd3, 14'd6000, 14'd300, 14'd2, 14'd768};
    logic [13:0] special_fs[7]  = '{14'd4096, 14'h3FFF, 14'd1, 14'd13, 14'd16, 14'd16, 14'd0};
    logic [13:0] special_bpp[7] = '{14'd16, 14'h3FFF, 14'd1, 14'd0, 14'd2, 14'd2, 14'd3};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: everything is invalid.
    queue_pixel(FACE_POS_X, 12'd0, 12'd0);
    queue_pixel(FACE_NEG_Z, 12'd4095, 12'd4095);
    wait_drained();

    set_geometry(14'd4096, 14'd3072, 14'd1024, 14'd4);
    for (int f = 0; f < 8; f++) begin
      queue_pixel(3'(f), 12'd0, 12'd0);
    end
    queue_pixel(FACE_POS_X, 12'd1023, 12'd1023);
    queue_pixel(FACE_POS_Z, 12'd4095, 12'd4095);
    queue_pixel(FACE_NEG_Z, 12'd4095, 12'd0);
    queue_pixel(FACE_NEG_Y, 12'd0, 12'd4095);
    queue_pixel(3'd7, 12'd4095, 12'd4095);
    queue_pixel(FACE_POS_Y, 12'd511, 12'd512);
    queue_pixel(FACE_NEG_X, 12'd1, 12'd1022);
    queue_pixel(3'd6, 12'd2048, 12'd1024);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (p < 7) begin
        set_geometry(special_w[p], special_h[p], special_fs[p], special_bpp[p]);
      end else begin
        set_geometry(14'($urandom_range(4, 8400)), 14'($urandom_range(3, 8400)),
                     14'($urandom_range(1, 4300)), 14'($urandom_range(0, 31)));
      end
      if (p == 0) begin
        // Hold the output while pixels keep coming, then pause until empty.
        rx_hold_req++;
        queue_random(80);
        wait_drained();
        queue_random(40);
        wait_drained();
      end
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
